// File: design/mbrp_pkg.sv
// Shared constants, types and the CRC byte function of the Modbus request parser.
`timescale 1ns / 1ps
package mbrp_pkg;

    localparam int          LEN_BITS_DEFAULT  = 9;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam int          MIN_FRAME_LEN     = 8;
    localparam int          CRC_BYTES         = 2;
    localparam int          HDR_DEPTH         = 7;
    localparam int          HDR_IDX_W         = $clog2(HDR_DEPTH);
    localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'h10;

    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] register_count;
        logic [7:0]  data_byte_count;
    } t_result;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: design/mbrp_ifs.sv
// Valid/ready channel interfaces for request bytes and parse results.
`timescale 1ns / 1ps
interface mbrp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface mbrp_res_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] register_count;
    logic [7:0]  data_byte_count;

    modport source (output valid, output frame_ok, output unit_id, output function_code,
                    output start_address, output register_count, output data_byte_count,
                    input ready);
    modport sink   (input valid, input frame_ok, input unit_id, input function_code,
                    input start_address, input register_count, input data_byte_count,
                    output ready);
endinterface

// File: design/mbrp_accum.sv
// Per-frame CRC, length and header accumulation with the end-of-frame check.
`timescale 1ns / 1ps
module mbrp_accum #(
    parameter int LENGTH_COUNTER_BITS = mbrp_pkg::LEN_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_end,
    output logic              o_res_valid,
    output mbrp_pkg::t_result o_res
);
    localparam int LW = LENGTH_COUNTER_BITS;
    localparam int CW = LENGTH_COUNTER_BITS + 1;

    logic [15:0]   r_crc, n_crc;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_hdr [mbrp_pkg::HDR_DEPTH];

    logic          crc_zero;
    logic          len_ok;
    logic          wm_long;
    logic [CW-1:0] need_len;

    always_comb begin
        n_crc = mbrp_pkg::crc16_byte(r_crc, i_data_byte);
        n_len = (r_len == {LW{1'b1}}) ? r_len : r_len + LW'(1);
    end

    // A frame that passes the length check has all header bytes stored before its last beat.
    always_comb begin
        crc_zero = (n_crc == 16'h0000);
        len_ok   = (n_len >= LW'(mbrp_pkg::MIN_FRAME_LEN));
        wm_long  = (r_hdr[1] == mbrp_pkg::FC_WRITE_MULTIPLE)
                 && (n_len >= LW'(mbrp_pkg::MIN_FRAME_LEN + 1));
        need_len = CW'(mbrp_pkg::HDR_DEPTH + mbrp_pkg::CRC_BYTES) + CW'(r_hdr[6]);
        o_res    = '0;
        if (len_ok && crc_zero) begin
            o_res.frame_ok       = 1'b1;
            o_res.unit_id        = r_hdr[0];
            o_res.function_code  = r_hdr[1];
            o_res.start_address  = {r_hdr[2], r_hdr[3]};
            o_res.register_count = {r_hdr[4], r_hdr[5]};
            if (wm_long) begin
                o_res.data_byte_count = r_hdr[6];
                o_res.frame_ok        = ({1'b0, n_len} >= need_len);
            end
        end
        o_res_valid = i_accept && i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mbrp_pkg::CRC_INIT;
            r_len <= '0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_crc <= mbrp_pkg::CRC_INIT;
                r_len <= '0;
            end else begin
                r_crc <= n_crc;
                r_len <= n_len;
            end
        end
    end

    // Store header bytes only; later bytes feed only the CRC and the length counter.
    always_ff @(posedge i_clk) begin
        if (i_accept && (r_len < LW'(mbrp_pkg::HDR_DEPTH))) begin
            r_hdr[r_len[mbrp_pkg::HDR_IDX_W-1:0]] <= i_data_byte;
        end
    end

endmodule

// File: design/mbrp_out_reg.sv
// One-entry result register that holds a finished result until the sink takes it.
`timescale 1ns / 1ps
module mbrp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mbrp_pkg::t_result i_res,
    output logic              o_free,
    mbrp_res_if.source        o_res
);
    logic              r_valid;
    mbrp_pkg::t_result r_res;

    // Free when empty or when the held beat leaves this cycle.
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.frame_ok        = r_res.frame_ok;
    assign o_res.unit_id         = r_res.unit_id;
    assign o_res.function_code   = r_res.function_code;
    assign o_res.start_address   = r_res.start_address;
    assign o_res.register_count  = r_res.register_count;
    assign o_res.data_byte_count = r_res.data_byte_count;

endmodule

// File: design/modbus_request_frame_parser_top.sv
// Top level of the Modbus RTU request frame parser.
// Takes one request byte per beat, every cycle unless a held result stalls it, with frame_end
// on the last byte. The CRC-16 (reflected, 0xA001, seed 0xFFFF) is updated combinationally
// over each byte, and the result of a frame appears on the output channel the cycle after
// its last byte is taken. The result register is the only buffer: a byte is taken while that
// register is empty or being drained, so a stalled sink holds off the byte stream. Throughput
// is one byte per cycle while the sink keeps up. The frame length counter is LENGTH_COUNTER_BITS
// wide and saturates on long frames.
`timescale 1ns / 1ps
module modbus_request_frame_parser_top #(
    parameter int LENGTH_COUNTER_BITS = mbrp_pkg::LEN_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbrp_req_if.sink  i_req,
    mbrp_res_if.source o_res
);
    logic              w_free;
    logic              w_accept;
    logic              w_res_valid;
    mbrp_pkg::t_result w_res;

    assign i_req.ready = w_free;
    assign w_accept    = i_req.valid && w_free;

    mbrp_accum #(
        .LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_req.data_byte),
        .i_frame_end (i_req.frame_end),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mbrp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_res   (o_res)
    );

endmodule
